>>> rtl/rscs_pkg.sv
// ----------------------------------------------------------------------------
// Rational soft clip shaper package
// Shared constants, widths and register codes for the soft clip shaper.
// ----------------------------------------------------------------------------
package rscs_pkg;

  // Register write port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN = 1'b0,
    REG_DRY_BLEND  = 1'b1
  } cfg_reg_e;

  // Drive gain held as (65536 + 20 * drive_gain), a Q5.16 value.
  localparam int GQ_W       = 21;
  localparam int GAIN_ONE   = 65536;
  localparam int GAIN_SCALE = 20;

  // Wet share is (131072 - dry_blend) at scale 2^17.
  localparam int WET_W    = 18;
  localparam int WET_FULL = 131072;

  // Mix accumulator sits at scale 2^(F+19); the result drops 19 bits.
  localparam int MIX_SHIFT = 19;

endpackage

>>> rtl/rscs_in_if.sv
// ----------------------------------------------------------------------------
// Input sample channel
// Valid/ready channel carrying one signed sample per transfer.
// ----------------------------------------------------------------------------
interface rscs_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/rscs_out_if.sv
// ----------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel carrying one shaped sample per transfer.
// ----------------------------------------------------------------------------
interface rscs_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/rscs_cfg_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rscs_cfg_if
  import rscs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rscs_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: produces one quotient bit and hands the
// partial remainder, divisor and sample sideband to the next cell.
// ----------------------------------------------------------------------------
module rscs_div_cell #(
  parameter int SB = 16,
  parameter int RW = 37,
  parameter int QB = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [RW-1:0]        rem_i,
  input  logic [RW-1:0]        den_i,
  input  logic [QB-1:0]        quo_i,
  input  logic                 neg_i,
  input  logic signed [SB-1:0] x_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [RW-1:0]        rem_o,
  output logic [RW-1:0]        den_o,
  output logic [QB-1:0]        quo_o,
  output logic                 neg_o,
  output logic signed [SB-1:0] x_o
);

  logic              en;
  logic [RW:0]       rem2;
  logic [RW:0]       den_ext;
  logic              ge;
  logic [RW-1:0]     rem_d;
  logic [QB-1:0]     quo_d;

  logic              valid_q;
  logic [RW-1:0]     rem_q;
  logic [RW-1:0]     den_q;
  logic [QB-1:0]     quo_q;
  logic              neg_q;
  logic signed [SB-1:0] x_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  assign rem2    = {rem_i, 1'b0};
  assign den_ext = {1'b0, den_i};
  assign ge      = (rem2 >= den_ext);

  // The remainder always stays below the divisor, so dropping the top bit is safe.
  always_comb begin
    if (ge) begin
      rem_d = RW'(rem2 - den_ext);
    end else begin
      rem_d = RW'(rem2);
    end
    quo_d = {quo_i[QB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
      neg_q <= neg_i;
      x_q   <= x_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign neg_o   = neg_q;
  assign x_o     = x_q;

endmodule

>>> rtl/rscs_mix.sv
// ----------------------------------------------------------------------------
// Wet/dry mixer
// Two stages: wet and dry products, then sum, round to nearest and saturate.
// ----------------------------------------------------------------------------
module rscs_mix
  import rscs_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [SB:0]           q_i,
  input  logic                  neg_i,
  input  logic signed [SB-1:0]  x_i,
  input  logic [CFG_DATA_W-1:0] dry_blend_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [SB-1:0]  sample_o
);

  localparam int F   = SB - 1;
  localparam int PW  = SB + 1 + WET_W;
  localparam int XW  = SB + CFG_DATA_W + 1;
  localparam int AW  = SB + 21;
  localparam int RSW = AW - MIX_SHIFT;

  localparam logic signed [RSW-1:0] SAT_HI = {3'b000, {F{1'b1}}};
  localparam logic signed [RSW-1:0] SAT_LO = {3'b111, {F{1'b0}}};
  localparam logic signed [AW-1:0]  ROUND_HALF = AW'(1) <<< (MIX_SHIFT - 1);

  logic en1, en2;

  logic [WET_W-1:0]               wet;
  logic signed [CFG_DATA_W:0]     dry_s;
  logic [PW-1:0]                  pw_d;
  logic signed [XW-1:0]           px_d;

  logic                           v1_q;
  logic [PW-1:0]                  pw_q;
  logic signed [XW-1:0]           px_q;
  logic                           neg1_q;

  logic signed [AW-1:0]           pws;
  logic signed [AW-1:0]           wet_term;
  logic signed [AW-1:0]           dry_term;
  logic signed [AW-1:0]           acc;
  logic signed [RSW-1:0]          r;
  logic signed [SB-1:0]           sat_d;

  logic                           v2_q;
  logic signed [SB-1:0]           out_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // First stage: both products, magnitude only for the wet side.
  assign wet   = WET_W'(WET_FULL) - WET_W'(dry_blend_i);
  assign dry_s = $signed({1'b0, dry_blend_i});
  assign pw_d  = PW'(q_i) * PW'(wet);
  assign px_d  = XW'(x_i) * XW'(dry_s);

  // Second stage: apply the sign of the sample to the wet product, add the
  // dry share (times four), round ties upward and clamp to the sample range.
  always_comb begin
    pws      = AW'($signed({1'b0, pw_q}));
    wet_term = neg1_q ? -pws : pws;
    dry_term = AW'(px_q) <<< 2;
    acc      = wet_term + dry_term + ROUND_HALF;
    r        = acc[AW-1:MIX_SHIFT];
    if (r > SAT_HI) begin
      sat_d = SAT_HI[SB-1:0];
    end else if (r < SAT_LO) begin
      sat_d = SAT_LO[SB-1:0];
    end else begin
      sat_d = r[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pw_q   <= pw_d;
      px_q   <= px_d;
      neg1_q <= neg_i;
    end
    if (en2) begin
      out_q <= sat_d;
    end
  end

  assign valid_o  = v2_q;
  assign sample_o = out_q;

endmodule

>>> rtl/rational_soft_clip_shaper.sv
// ----------------------------------------------------------------------------
// Rational soft clip shaper
// Throughput: one sample per cycle while the output accepts; the divider is
// a row of SAMPLE_BITS + 1 cells, one quotient bit each, so it never holds
// the stream back unless the output stalls. Reset clears all valid flags,
// sets the drive gain to unity (65536) and the dry blend register to zero.
// ----------------------------------------------------------------------------
module rational_soft_clip_shaper
  import rscs_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rscs_in_if.sink     in_i,
  rscs_out_if.source  out_o,
  rscs_cfg_if.sink    cfg_i
);

  // Fraction bits of a sample, quotient bits and the divider word width.
  // The driven magnitude a = |x| * gq is below 2^(F+21) and the divisor
  // 2^(F+16) + a below 2^(F+22), so RW bits hold every remainder.
  localparam int SB = SAMPLE_BITS;
  localparam int F  = SB - 1;
  localparam int QB = F + 2;
  localparam int RW = F + 22;

  localparam logic [RW-1:0] DEN_BASE = RW'(1) << (F + 16);

  // ---------------------------------------------------------------------------
  // Registers. The drive register is kept directly as the Q5.16 gain 65536 +
  // 20 * drive_gain, so nothing is computed on it in the data path. Writes must
  // come only while the pipeline is empty (not enforced here) to act at once.
  // ---------------------------------------------------------------------------
  logic [GQ_W-1:0]       gq_q;
  logic [CFG_DATA_W-1:0] dry_blend_q;
  cfg_reg_e              cfg_sel;

  assign cfg_i.ready = 1'b1;
  assign cfg_sel     = cfg_reg_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gq_q        <= GQ_W'(GAIN_ONE);
      dry_blend_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_sel)
        REG_DRIVE_GAIN: begin
          gq_q <= GQ_W'(GAIN_ONE) + GQ_W'(cfg_i.data) * GQ_W'(GAIN_SCALE);
        end
        REG_DRY_BLEND: begin
          dry_blend_q <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Every stage moves forward when it is empty or the stage after it moves,
  // so bubbles collapse; input keeps flowing while a result waits, until the stages fill.
  // ---------------------------------------------------------------------------

  // Drive stage: magnitude of the sample times the gain.
  logic                 en_a;
  logic                 en_p;
  logic                 neg_in;
  logic [SB-1:0]        mag_in;
  logic [RW-1:0]        a_d;

  logic                 va_q;
  logic [RW-1:0]        a_q;
  logic                 nega_q;
  logic signed [SB-1:0] xa_q;

  // The most negative sample negates to 2^F, which is exactly its magnitude
  // when read as unsigned.
  assign neg_in = in_i.sample_in[SB-1];
  assign mag_in = neg_in ? SB'(-in_i.sample_in) : SB'(in_i.sample_in);
  assign a_d    = RW'(mag_in) * RW'(gq_q);

  assign en_a       = !va_q || en_p;
  assign in_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_q    <= a_d;
      nega_q <= neg_in;
      xa_q   <= in_i.sample_in;
    end
  end

  // Divisor stage: the clipper needs a / (2^(F+16) + a); the dividend a
  // starts as the partial remainder.
  logic                 v_s   [QB+1];
  logic                 rdy_s [QB+1];
  logic [RW-1:0]        rem_s [QB+1];
  logic [RW-1:0]        den_s [QB+1];
  logic [QB-1:0]        quo_s [QB+1];
  logic                 neg_s [QB+1];
  logic signed [SB-1:0] x_s   [QB+1];

  logic                 vp_q;
  logic [RW-1:0]        remp_q;
  logic [RW-1:0]        denp_q;
  logic                 negp_q;
  logic signed [SB-1:0] xp_q;

  assign en_p = !vp_q || rdy_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_p) begin
      vp_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p) begin
      remp_q <= a_q;
      denp_q <= DEN_BASE + a_q;
      negp_q <= nega_q;
      xp_q   <= xa_q;
    end
  end

  assign v_s[0]   = vp_q;
  assign rem_s[0] = remp_q;
  assign den_s[0] = denp_q;
  assign quo_s[0] = '0;
  assign neg_s[0] = negp_q;
  assign x_s[0]   = xp_q;

  // Divider row: cell k settles quotient bit QB-1-k, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_div
    rscs_div_cell #(
      .SB (SB),
      .RW (RW),
      .QB (QB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_s[k]),
      .ready_o (rdy_s[k]),
      .rem_i   (rem_s[k]),
      .den_i   (den_s[k]),
      .quo_i   (quo_s[k]),
      .neg_i   (neg_s[k]),
      .x_i     (x_s[k]),
      .valid_o (v_s[k+1]),
      .ready_i (rdy_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .den_o   (den_s[k+1]),
      .quo_o   (quo_s[k+1]),
      .neg_o   (neg_s[k+1]),
      .x_o     (x_s[k+1])
    );
  end

  // Mixer: the truncated quotient is the clipped magnitude at F+2 fraction
  // bits; it takes the sample's sign and is blended with the dry sample.
  rscs_mix #(
    .SB (SB)
  ) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v_s[QB]),
    .ready_o     (rdy_s[QB]),
    .q_i         (quo_s[QB]),
    .neg_i       (neg_s[QB]),
    .x_i         (x_s[QB]),
    .dry_blend_i (dry_blend_q),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .sample_o    (out_o.sample_out)
  );

  // The final remainder is not needed past the last cell.
  logic unused_rem;
  assign unused_rem = ^rem_s[QB] ^ ^den_s[QB];

endmodule
